@@ rtl/i2cm_pkg.sv @@
// Shared types and constants of the bit-level I2C master.
// No dependencies; used by the front, back and top-level files.
package i2cm_pkg;

  // Ticks per bus phase after reset.
  localparam logic [15:0] PHASE_LEN_RESET = 16'd30;

  // Command codes as they arrive on the input channel.
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_START    = 4'd1,
    CMD_STOP     = 4'd2,
    CMD_WRITE    = 4'd3,
    CMD_READ     = 4'd4,
    CMD_ACK      = 4'd5,
    CMD_NACK     = 4'd6,
    CMD_WAIT_ACK = 4'd7,
    CMD_PROBE    = 4'd8
  } cmd_e;

  // One classified tick, as queued between front and back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic       sda;
    logic       bus_idle;
  } front_item_t;

  // One result beat.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_value;
    logic       nack;
  } res_t;

endpackage

@@ rtl/i2cm_fifo.sv @@
// Small first-in first-out queue with a combinational head.
// No dependencies; instanced by the front and back of the I2C master.
module i2cm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ rtl/i2cm_front.sv @@
// Front of the I2C master: accepts input beats, classifies the command
// and queues the tick for the sequencer. Depends on i2cm_pkg, i2cm_fifo.
module i2cm_front #(
  parameter int DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [3:0]            command_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  sda_level_i,
  input  logic                  scl_level_i,
  output i2cm_pkg::front_item_t item_o,
  output logic                  item_valid_o,
  input  logic                  item_pop_i
);

  i2cm_pkg::front_item_t cls;
  logic                  full, empty;

  // Fold unknown codes into no command; precompute the bus-idle check.
  always_comb begin
    cls.cmd      = (command_i <= i2cm_pkg::CMD_PROBE) ? i2cm_pkg::cmd_e'(command_i)
                                                      : i2cm_pkg::CMD_NONE;
    cls.data     = data_byte_i;
    cls.sda      = sda_level_i;
    cls.bus_idle = sda_level_i & scl_level_i;
  end

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::front_item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (cls),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (item_o),
    .empty_o (empty)
  );

  assign in_stall_o   = full;
  assign item_valid_o = !empty;

endmodule

@@ rtl/i2cm_back.sv @@
// Back of the I2C master: phase sequencer that advances one tick per
// queued beat and queues the result. Depends on i2cm_pkg, i2cm_fifo.
module i2cm_back #(
  parameter int DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cm_pkg::front_item_t item_i,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_data_i,
  output i2cm_pkg::res_t        res_o,
  output logic                  res_valid_o,
  input  logic                  res_stall_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'd0,
    S_ST_A  = 5'd1,
    S_ST_B  = 5'd2,
    S_ST_C  = 5'd3,
    S_STOP  = 5'd4,
    S_WR_A  = 5'd5,
    S_WR_B  = 5'd6,
    S_WR_C  = 5'd7,
    S_RD_A  = 5'd8,
    S_RD_B  = 5'd9,
    S_AK_A  = 5'd10,
    S_AK_B  = 5'd11,
    S_AK_C  = 5'd12,
    S_NK_A  = 5'd13,
    S_NK_B  = 5'd14,
    S_NK_C  = 5'd15,
    S_WA_A  = 5'd16,
    S_WA_B  = 5'd17,
    S_WA_C  = 5'd18
  } step_e;

  typedef enum logic [2:0] {
    PR_NONE  = 3'd0,
    PR_START = 3'd1,
    PR_ADDR  = 3'd2,
    PR_ACK   = 3'd3,
    PR_STOP  = 3'd4
  } probe_e;

  step_e       step_q, step_d;
  logic [15:0] len_q, pc_q, pc_d;
  logic [3:0]  bi_q, bi_d;
  logic [7:0]  sv_q, sv_d, rh_q, rh_d;
  probe_e      ps_q, ps_d;
  logic        ack_q, ack_d, scl_q, scl_d, sda_q, sda_d;
  logic        done;
  logic        res_full, res_empty, step_en;
  logic [16:0] len_eff;
  i2cm_pkg::res_t res;

  assign step_en    = item_valid_i && !res_full;
  assign item_pop_o = step_en;
  assign len_eff    = (len_q == '0) ? 17'd1 : {1'b0, len_q};

  always_comb begin
    step_e nxt;
    logic  do_enter;
    logic  end_seq;
    nxt      = S_IDLE;
    do_enter = 1'b0;
    end_seq  = 1'b0;
    step_d   = step_q;
    pc_d     = pc_q;
    bi_d     = bi_q;
    sv_d     = sv_q;
    rh_d     = rh_q;
    ps_d     = ps_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    done     = 1'b0;

    if (step_q != S_IDLE) begin
      if ({1'b0, pc_q} + 17'd1 < len_eff) begin
        pc_d = pc_q + 16'd1;
      end else begin
        case (step_q)
          S_ST_A: begin nxt = S_ST_B; do_enter = 1'b1; end
          S_ST_B: begin nxt = S_ST_C; do_enter = 1'b1; end
          S_STOP: begin sda_d = 1'b1; end_seq = 1'b1; end
          S_WR_A: begin nxt = S_WR_B; do_enter = 1'b1; end
          S_WR_B: begin nxt = S_WR_C; do_enter = 1'b1; end
          S_WR_C: begin
            bi_d = bi_q + 4'd1;
            if (bi_d[3]) begin
              end_seq = 1'b1;
            end else begin
              nxt = S_WR_A; do_enter = 1'b1;
            end
          end
          S_RD_A: begin
            sv_d = {sv_q[6:0], item_i.sda};
            nxt = S_RD_B; do_enter = 1'b1;
          end
          S_RD_B: begin
            bi_d = bi_q + 4'd1;
            if (bi_d[3]) begin
              rh_d = sv_q; end_seq = 1'b1;
            end else begin
              nxt = S_RD_A; do_enter = 1'b1;
            end
          end
          S_AK_A: begin nxt = S_AK_B; do_enter = 1'b1; end
          S_AK_B: begin nxt = S_AK_C; do_enter = 1'b1; end
          S_AK_C: begin sda_d = 1'b1; end_seq = 1'b1; end
          S_NK_A: begin nxt = S_NK_B; do_enter = 1'b1; end
          S_NK_B: begin nxt = S_NK_C; do_enter = 1'b1; end
          S_WA_A: begin nxt = S_WA_B; do_enter = 1'b1; end
          S_WA_B: begin ack_d = item_i.sda; nxt = S_WA_C; do_enter = 1'b1; end
          default: end_seq = 1'b1;
        endcase
      end
    end else begin
      case (item_i.cmd)
        i2cm_pkg::CMD_START: begin ps_d = PR_NONE; nxt = S_ST_A; do_enter = 1'b1; end
        i2cm_pkg::CMD_STOP:  begin ps_d = PR_NONE; nxt = S_STOP; do_enter = 1'b1; end
        i2cm_pkg::CMD_WRITE: begin
          ps_d = PR_NONE; sv_d = item_i.data; bi_d = '0; nxt = S_WR_A; do_enter = 1'b1;
        end
        i2cm_pkg::CMD_READ: begin
          ps_d = PR_NONE; sv_d = '0; bi_d = '0; nxt = S_RD_A; do_enter = 1'b1;
        end
        i2cm_pkg::CMD_ACK:      begin ps_d = PR_NONE; nxt = S_AK_A; do_enter = 1'b1; end
        i2cm_pkg::CMD_NACK:     begin ps_d = PR_NONE; nxt = S_NK_A; do_enter = 1'b1; end
        i2cm_pkg::CMD_WAIT_ACK: begin ps_d = PR_NONE; nxt = S_WA_A; do_enter = 1'b1; end
        i2cm_pkg::CMD_PROBE: begin
          if (item_i.bus_idle) begin
            sv_d = item_i.data; ps_d = PR_START; nxt = S_ST_A; do_enter = 1'b1;
          end else begin
            ack_d = 1'b1; ps_d = PR_NONE; done = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Chain the probe stages, otherwise close the command.
    if (end_seq) begin
      case (ps_d)
        PR_START: begin ps_d = PR_ADDR; bi_d = '0; nxt = S_WR_A; do_enter = 1'b1; end
        PR_ADDR:  begin ps_d = PR_ACK; nxt = S_WA_A; do_enter = 1'b1; end
        PR_ACK:   begin ps_d = PR_STOP; nxt = S_STOP; do_enter = 1'b1; end
        default: begin ps_d = PR_NONE; step_d = S_IDLE; pc_d = '0; done = 1'b1; end
      endcase
    end

    if (do_enter) begin
      step_d = nxt;
      pc_d   = '0;
      case (nxt)
        S_ST_A: begin sda_d = 1'b1; scl_d = 1'b1; end
        S_ST_B: sda_d = 1'b0;
        S_ST_C: scl_d = 1'b0;
        S_STOP: begin sda_d = 1'b0; scl_d = 1'b1; end
        S_WR_A: sda_d = sv_d[~bi_d[2:0]];
        S_WR_B: scl_d = 1'b1;
        S_WR_C: begin
          scl_d = 1'b0;
          if (bi_d == 4'd7) sda_d = 1'b1;
        end
        S_RD_A: begin sda_d = 1'b1; scl_d = 1'b1; end
        S_RD_B: scl_d = 1'b0;
        S_AK_A: sda_d = 1'b0;
        S_AK_B: scl_d = 1'b1;
        S_AK_C: scl_d = 1'b0;
        S_NK_A: sda_d = 1'b1;
        S_NK_B: scl_d = 1'b1;
        S_NK_C: scl_d = 1'b0;
        S_WA_A: sda_d = 1'b1;
        S_WA_B: scl_d = 1'b1;
        S_WA_C: scl_d = 1'b0;
        default: step_d = S_IDLE;
      endcase
    end

    res.scl        = scl_d;
    res.sda        = sda_d;
    res.busy       = (step_d != S_IDLE);
    res.done       = done;
    res.read_value = rh_d;
    res.nack       = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
      len_q  <= i2cm_pkg::PHASE_LEN_RESET;
      pc_q   <= '0;
      bi_q   <= '0;
      sv_q   <= '0;
      rh_q   <= '0;
      ps_q   <= PR_NONE;
      ack_q  <= 1'b1;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (step_en) begin
        step_q <= step_d;
        pc_q   <= pc_d;
        bi_q   <= bi_d;
        sv_q   <= sv_d;
        rh_q   <= rh_d;
        ps_q   <= ps_d;
        ack_q  <= ack_d;
        scl_q  <= scl_d;
        sda_q  <= sda_d;
      end
    end
  end

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::res_t)),
    .DEPTH (DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_en),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (!res_stall_i),
    .data_o  (res_o),
    .empty_o (res_empty)
  );

  assign res_valid_o = !res_empty;

endmodule

@@ rtl/i2c_bit_level_master.sv @@
// Top level of the bit-level open-drain I2C master.
// Depends on i2cm_pkg, i2cm_front, i2cm_back (and i2cm_fifo through them).
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one beat per system tick, with
//    the sampled SDA/SCL levels and a command (acted on only while idle).
//  - Output channel (out_valid_o / out_stall_i): exactly one result beat per
//    input beat, in order: line drives, busy, done pulse, last read byte and
//    the ack/no-device flag.
//  - Config channel (cfg_valid_i / cfg_ready_o): writes phase_length, the
//    ticks per bus phase; always ready. Write it only while no beat is in
//    flight; the next beat runs at the new length.
//  - Path: each input beat is registered in the input queue, its result in
//    the result queue; it leaves there when out_stall_i is low.
//  - Throughput: one beat per cycle while the result queue is not full, set
//    by the sequencer, which updates its phase state once per beat.
//  - Reset: queues empty, sequencer idle, both lines released, nack flag set,
//    phase_length back to 30 ticks.
//  - Stall: a stalled receiver fills the result queue; the sequencer then
//    holds, the input queue fills and in_stall_o rises. No beat is dropped.
module i2c_bit_level_master #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        sda_level_i,
  input  logic        scl_level_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_drive_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_value_o,
  output logic        nack_seen_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  i2cm_pkg::front_item_t item;
  i2cm_pkg::res_t        res;
  logic                  item_valid, item_pop;

  // Classify and queue incoming beats.
  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .sda_level_i  (sda_level_i),
    .scl_level_i  (scl_level_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // Advance the bus sequencer one tick per queued beat.
  i2cm_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_o        (res),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i)
  );

  // The phase length register takes a write on any cycle.
  assign cfg_ready_o = 1'b1;

  assign scl_drive_o  = res.scl;
  assign sda_drive_o  = res.sda;
  assign busy_res_o   = res.busy;
  assign done_res_o   = res.done;
  assign read_value_o = res.read_value;
  assign nack_seen_o  = res.nack;

endmodule

@@ sim/i2c_bit_level_master_checker.sv @@
// Checker for the bit-level I2C master: watches the input, result and config
// channels, predicts every result beat and compares it field by field.
// Depends on i2cm_pkg for the command codes, the result struct and reset values.
`timescale 1ns / 1ps

module i2c_bit_level_master_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        sda_level_i,
  input  logic        scl_level_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        scl_drive_i,
  input  logic        sda_drive_i,
  input  logic        busy_res_i,
  input  logic        done_res_i,
  input  logic [7:0]  read_value_i,
  input  logic        nack_seen_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int BYTE_BITS = 8;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'd0,
    ST_START_REL  = 5'd1,
    ST_START_SDA  = 5'd2,
    ST_START_SCL  = 5'd3,
    ST_STOP       = 5'd4,
    ST_WR_SETUP   = 5'd5,
    ST_WR_HIGH    = 5'd6,
    ST_WR_LOW     = 5'd7,
    ST_RD_HIGH    = 5'd8,
    ST_RD_LOW     = 5'd9,
    ST_ACK_SETUP  = 5'd10,
    ST_ACK_HIGH   = 5'd11,
    ST_ACK_LOW    = 5'd12,
    ST_NACK_SETUP = 5'd13,
    ST_NACK_HIGH  = 5'd14,
    ST_NACK_LOW   = 5'd15,
    ST_WA_SETUP   = 5'd16,
    ST_WA_HIGH    = 5'd17,
    ST_WA_LOW     = 5'd18
  } seq_step_e;

  typedef enum logic [2:0] {
    PR_NONE  = 3'd0,
    PR_START = 3'd1,
    PR_ADDR  = 3'd2,
    PR_ACK   = 3'd3,
    PR_STOP  = 3'd4
  } probe_stage_e;

  // Predicted sequencer state.
  logic [15:0]  phase_len;
  logic [15:0]  phase_cnt;
  seq_step_e    step;
  logic [3:0]   bit_idx;
  logic [7:0]   shift_byte;
  probe_stage_e probe;
  logic         ack_bit;
  logic         scl_q;
  logic         sda_q;
  logic [7:0]   read_byte;
  logic         done_q;

  i2cm_pkg::res_t due_bus_beats[$];
  i2cm_pkg::res_t next_beat;
  i2cm_pkg::res_t want;
  int             fail_count = 0;

  task enter_step(input seq_step_e s);
    step      = s;
    phase_cnt = '0;
    case (s)
      ST_START_REL:  begin sda_q = 1'b1; scl_q = 1'b1; end
      ST_START_SDA:  sda_q = 1'b0;
      ST_START_SCL:  scl_q = 1'b0;
      ST_STOP:       begin sda_q = 1'b0; scl_q = 1'b1; end
      ST_WR_SETUP:   sda_q = shift_byte[7 - bit_idx[2:0]];
      ST_WR_HIGH:    scl_q = 1'b1;
      ST_WR_LOW:     begin
        scl_q = 1'b0;
        if (bit_idx == 4'd7) sda_q = 1'b1;
      end
      ST_RD_HIGH:    begin sda_q = 1'b1; scl_q = 1'b1; end
      ST_RD_LOW:     scl_q = 1'b0;
      ST_ACK_SETUP:  sda_q = 1'b0;
      ST_ACK_HIGH:   scl_q = 1'b1;
      ST_ACK_LOW:    scl_q = 1'b0;
      ST_NACK_SETUP: sda_q = 1'b1;
      ST_NACK_HIGH:  scl_q = 1'b1;
      ST_NACK_LOW:   scl_q = 1'b0;
      ST_WA_SETUP:   sda_q = 1'b1;
      ST_WA_HIGH:    scl_q = 1'b1;
      ST_WA_LOW:     scl_q = 1'b0;
      default:       step = ST_IDLE;
    endcase
  endtask

  // Chain the probe stages, or close the command with a done pulse.
  task finish_sequence();
    case (probe)
      PR_START: begin
        probe   = PR_ADDR;
        bit_idx = '0;
        enter_step(ST_WR_SETUP);
      end
      PR_ADDR: begin
        probe = PR_ACK;
        enter_step(ST_WA_SETUP);
      end
      PR_ACK: begin
        probe = PR_STOP;
        enter_step(ST_STOP);
      end
      default: begin
        probe     = PR_NONE;
        step      = ST_IDLE;
        phase_cnt = '0;
        done_q    = 1'b1;
      end
    endcase
  endtask

  // Advance the sequencer by one tick and produce the beat it shows.
  task advance_sequencer(input logic [3:0] cmd, input logic [7:0] data, input logic sda,
                         input logic scl, output i2cm_pkg::res_t beat);
    logic [16:0] len;
    len    = (phase_len == '0) ? 17'd1 : {1'b0, phase_len};
    done_q = 1'b0;
    if (step != ST_IDLE) begin
      if ({1'b0, phase_cnt} + 17'd1 < len) begin
        phase_cnt = phase_cnt + 16'd1;
      end else begin
        case (step)
          ST_START_REL: enter_step(ST_START_SDA);
          ST_START_SDA: enter_step(ST_START_SCL);
          ST_STOP:      begin sda_q = 1'b1; finish_sequence(); end
          ST_WR_SETUP:  enter_step(ST_WR_HIGH);
          ST_WR_HIGH:   enter_step(ST_WR_LOW);
          ST_WR_LOW: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BYTE_BITS) finish_sequence();
            else enter_step(ST_WR_SETUP);
          end
          ST_RD_HIGH: begin
            shift_byte = {shift_byte[6:0], sda};
            enter_step(ST_RD_LOW);
          end
          ST_RD_LOW: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BYTE_BITS) begin
              read_byte = shift_byte;
              finish_sequence();
            end else begin
              enter_step(ST_RD_HIGH);
            end
          end
          ST_ACK_SETUP:  enter_step(ST_ACK_HIGH);
          ST_ACK_HIGH:   enter_step(ST_ACK_LOW);
          ST_ACK_LOW:    begin sda_q = 1'b1; finish_sequence(); end
          ST_NACK_SETUP: enter_step(ST_NACK_HIGH);
          ST_NACK_HIGH:  enter_step(ST_NACK_LOW);
          ST_WA_SETUP:   enter_step(ST_WA_HIGH);
          ST_WA_HIGH:    begin ack_bit = sda; enter_step(ST_WA_LOW); end
          default:       finish_sequence();
        endcase
      end
    end else begin
      case (cmd)
        i2cm_pkg::CMD_START: begin probe = PR_NONE; enter_step(ST_START_REL); end
        i2cm_pkg::CMD_STOP:  begin probe = PR_NONE; enter_step(ST_STOP); end
        i2cm_pkg::CMD_WRITE: begin
          probe      = PR_NONE;
          shift_byte = data;
          bit_idx    = '0;
          enter_step(ST_WR_SETUP);
        end
        i2cm_pkg::CMD_READ: begin
          probe      = PR_NONE;
          shift_byte = '0;
          bit_idx    = '0;
          enter_step(ST_RD_HIGH);
        end
        i2cm_pkg::CMD_ACK:      begin probe = PR_NONE; enter_step(ST_ACK_SETUP); end
        i2cm_pkg::CMD_NACK:     begin probe = PR_NONE; enter_step(ST_NACK_SETUP); end
        i2cm_pkg::CMD_WAIT_ACK: begin probe = PR_NONE; enter_step(ST_WA_SETUP); end
        i2cm_pkg::CMD_PROBE: begin
          if (sda && scl) begin
            shift_byte = data;
            probe      = PR_START;
            enter_step(ST_START_REL);
          end else begin
            // busy bus: no device, done at once
            ack_bit = 1'b1;
            probe   = PR_NONE;
            done_q  = 1'b1;
          end
        end
        default: ;
      endcase
    end
    beat = '{scl: scl_q, sda: sda_q, busy: (step != ST_IDLE), done: done_q,
             read_value: read_byte, nack: ack_bit};
  endtask

  function automatic int field_check(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_len  = i2cm_pkg::PHASE_LEN_RESET;
      phase_cnt  = '0;
      step       = ST_IDLE;
      bit_idx    = '0;
      shift_byte = '0;
      probe      = PR_NONE;
      ack_bit    = 1'b1;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      read_byte  = '0;
      done_q     = 1'b0;
      due_bus_beats.delete();
      pending_o <= 0;
      errors_o  <= fail_count;
    end else begin
      if (cfg_valid_i && cfg_ready_i) phase_len = cfg_data_i;
      // predict first, so a beat taken now is queued before any compare
      if (in_valid_i && !in_stall_i) begin
        advance_sequencer(command_i, data_byte_i, sda_level_i, scl_level_i, next_beat);
        due_bus_beats.push_back(next_beat);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_bus_beats.size() == 0) begin
          $error("result beat arrived with no prediction waiting");
          fail_count++;
        end else begin
          want = due_bus_beats.pop_front();
          fail_count += field_check("scl_drive", 8'(want.scl), 8'(scl_drive_i));
          fail_count += field_check("sda_drive", 8'(want.sda), 8'(sda_drive_i));
          fail_count += field_check("busy_res", 8'(want.busy), 8'(busy_res_i));
          fail_count += field_check("done_res", 8'(want.done), 8'(done_res_i));
          fail_count += field_check("read_value", want.read_value, read_value_i);
          fail_count += field_check("nack_seen", 8'(want.nack), 8'(nack_seen_i));
        end
      end
      pending_o <= due_bus_beats.size();
      errors_o  <= fail_count;
    end
  end

endmodule

@@ sim/i2c_bit_level_master_tb.sv @@
// Testbench top for the bit-level I2C master: drives ticks, config writes and
// receiver stalls, and gives the verdict. Depends on i2cm_pkg, the RTL and
// i2c_bit_level_master_checker.
`timescale 1ns / 1ps

module i2c_bit_level_master_tb;

  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 4;         // margin after every predicted beat has come back
  localparam int DIRECTED_GAP   = 40;        // quiet ticks after commands sent while busy
  localparam int RUN_LIMIT_NS   = 2_000_000;

  // Phases per command, used to size the quiet ticks after a directed command.
  localparam int START_PHASES = 3;
  localparam int STOP_PHASES  = 1;
  localparam int BYTE_PHASES  = 24;
  localparam int READ_PHASES  = 16;
  localparam int ACK_PHASES   = 3;
  localparam int PROBE_PHASES = 31;          // longest command: start, byte, ack, stop

  // Bus level selection for quiet ticks.
  localparam int LEVEL_LOW    = 0;
  localparam int LEVEL_HIGH   = 1;
  localparam int LEVEL_RANDOM = 2;

  // Receiver stall patterns.
  localparam int STALL_NONE    = 0;
  localparam int STALL_SCATTER = 1;
  localparam int STALL_STRETCH = 2;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [3:0]  command_i   = i2cm_pkg::CMD_NONE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        sda_level_i = 1'b1;
  logic        scl_level_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_drive_o;
  logic        sda_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_value_o;
  logic        nack_seen_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = 16'd0;

  int errors;
  int pending;

  int unsigned burst_left = 0;
  int unsigned stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  always #5 clk_i = ~clk_i;

  i2c_bit_level_master u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .sda_level_i  (sda_level_i),
    .scl_level_i  (scl_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scl_drive_o  (scl_drive_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_value_o (read_value_o),
    .nack_seen_o  (nack_seen_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  i2c_bit_level_master_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .sda_level_i  (sda_level_i),
    .scl_level_i  (scl_level_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scl_drive_i  (scl_drive_o),
    .sda_drive_i  (sda_drive_o),
    .busy_res_i   (busy_res_o),
    .done_res_i   (done_res_o),
    .read_value_i (read_value_o),
    .nack_seen_i  (nack_seen_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Receiver: switch between no stall, scattered stalls and long stretches so
  // back-pressure reaches every phase of the sequencer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_STRETCH);
        mode_left  = $urandom_range(32, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_SCATTER: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_STRETCH: begin
          if (stall_left != 0) begin
            stall_left--;
            out_stall_i <= 1'b1;
          end else begin
            out_stall_i <= 1'b0;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
          end
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Bus levels lean high, so probes find an idle bus about half the time.
  function automatic logic pick_level(int sel);
    case (sel)
      LEVEL_LOW:  return 1'b0;
      LEVEL_HIGH: return 1'b1;
      default:    return ($urandom_range(0, 3) != 0);
    endcase
  endfunction

  // Send one tick beat. Call right after a rising edge; returns right after
  // the edge that took the beat. Between bursts valid may drop for a random gap.
  task automatic send_tick(input logic [3:0] cmd, input logic [7:0] data,
                           input logic sda, input logic scl);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data;
    sda_level_i <= sda;
    scl_level_i <= scl;
    // hold the beat until the block takes it
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Ticks with no command, so a running sequence can advance to its end.
  task automatic send_quiet_ticks(input int unsigned n, input int sda_sel);
    repeat (n) send_tick(i2cm_pkg::CMD_NONE, 8'($urandom_range(0, 255)),
                         pick_level(sda_sel), pick_level(LEVEL_RANDOM));
  endtask

  // Random ticks: mostly real commands (taken whenever the sequencer is idle,
  // ignored while busy), with some empty ticks and out-of-range codes.
  task automatic send_random_ticks(input int unsigned n);
    int unsigned pick;
    logic [3:0]  cmd;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) cmd = i2cm_pkg::CMD_NONE;
      else if (pick < 14) cmd = 4'($urandom_range(9, 15));
      else cmd = 4'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_PROBE));
      send_tick(cmd, 8'($urandom_range(0, 255)), pick_level(LEVEL_RANDOM),
                pick_level(LEVEL_RANDOM));
    end
  endtask

  // Drop valid and wait until every predicted beat has come back, then let
  // the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write phase_length once no beat is in flight; a running sequence
  // carries on at the new length.
  task automatic change_phase_len(input logic [15:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Directed command followed by enough quiet ticks to finish at one tick per phase.
  task automatic directed(input logic [3:0] cmd, input logic [7:0] data, input logic sda,
                          input logic scl, input int quiet_sda, input int unsigned phases);
    send_tick(cmd, data, sda, scl);
    send_quiet_ticks(phases + 1, quiet_sda);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset phase length: a command or two at 30 ticks per phase.
    send_random_ticks(60);

    // Directed part at one tick per phase; first let any running command end.
    change_phase_len(16'd1);
    send_quiet_ticks(PROBE_PHASES + 1, LEVEL_RANDOM);
    directed(i2cm_pkg::CMD_START, 8'h00, 1'b1, 1'b1, LEVEL_RANDOM, START_PHASES);
    directed(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b1, LEVEL_RANDOM, BYTE_PHASES);
    directed(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0, LEVEL_RANDOM, BYTE_PHASES);
    directed(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b1, 1'b1, LEVEL_LOW, ACK_PHASES);   // ack
    directed(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b1, 1'b1, LEVEL_HIGH, ACK_PHASES);  // no ack
    directed(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b1, LEVEL_HIGH, READ_PHASES);     // all ones
    directed(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, 1'b1, LEVEL_LOW, READ_PHASES);      // all zeros
    directed(i2cm_pkg::CMD_READ, 8'h5A, 1'b1, 1'b0, LEVEL_RANDOM, READ_PHASES);
    directed(i2cm_pkg::CMD_ACK, 8'h00, 1'b1, 1'b1, LEVEL_RANDOM, ACK_PHASES);
    directed(i2cm_pkg::CMD_NACK, 8'h00, 1'b1, 1'b1, LEVEL_RANDOM, ACK_PHASES);
    directed(i2cm_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1, LEVEL_RANDOM, STOP_PHASES);
    // Probe on an idle bus, device answers, then device silent.
    directed(i2cm_pkg::CMD_PROBE, 8'hA0, 1'b1, 1'b1, LEVEL_LOW, PROBE_PHASES);
    directed(i2cm_pkg::CMD_PROBE, 8'hFF, 1'b1, 1'b1, LEVEL_HIGH, PROBE_PHASES);
    // Probe on a busy bus: SDA low, SCL low, both low.
    directed(i2cm_pkg::CMD_PROBE, 8'hA1, 1'b0, 1'b1, LEVEL_RANDOM, 0);
    directed(i2cm_pkg::CMD_PROBE, 8'h00, 1'b1, 1'b0, LEVEL_RANDOM, 0);
    directed(i2cm_pkg::CMD_PROBE, 8'h55, 1'b0, 1'b0, LEVEL_RANDOM, 0);
    // Idle codes that must not start anything.
    directed(i2cm_pkg::CMD_NONE, 8'hFF, 1'b0, 1'b0, LEVEL_RANDOM, 0);
    directed(4'd9, 8'hFF, 1'b1, 1'b1, LEVEL_RANDOM, 0);
    directed(4'd15, 8'h00, 1'b1, 1'b1, LEVEL_RANDOM, 0);
    // Commands that arrive while a write is running are ignored.
    send_tick(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b1, 1'b1);
    send_tick(i2cm_pkg::CMD_START, 8'h00, 1'b1, 1'b1);
    send_tick(i2cm_pkg::CMD_PROBE, 8'h3C, 1'b1, 1'b1);
    send_tick(i2cm_pkg::CMD_READ, 8'hC3, 1'b0, 1'b1);
    send_quiet_ticks(DIRECTED_GAP, LEVEL_RANDOM);

    // Longest phase: a stop runs for a while, then a short length ends it.
    change_phase_len(16'hFFFF);
    send_tick(i2cm_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1);
    send_quiet_ticks(20, LEVEL_RANDOM);
    change_phase_len(16'd2);
    send_random_ticks(60);

    // Zero phase length behaves as one tick per phase.
    change_phase_len(16'd0);
    send_random_ticks(40);

    change_phase_len(16'd3);
    send_random_ticks(60);

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hang, e.g. a result that never comes back.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/i2cm_pkg.sv
rtl/i2cm_fifo.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_bit_level_master.sv
sim/i2c_bit_level_master_checker.sv
sim/i2c_bit_level_master_tb.sv
